FILE: hw/rtl/dot_product_threshold_mask_unit_defines.svh
// Assertion macros used by the back end RTL
`ifndef DOT_PRODUCT_THRESHOLD_MASK_UNIT_DEFINES_SVH
`define DOT_PRODUCT_THRESHOLD_MASK_UNIT_DEFINES_SVH

// Implication checked on every rising edge outside reset
`define DPT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked outside reset
`define DPT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/dptm_pkg.sv
// ----------------------------------------------------------------------------
// dptm_pkg
// Shared types and constants of the dot product threshold mask unit.
// ----------------------------------------------------------------------------
package dptm_pkg;

  localparam int unsigned Dim = 32;
  localparam int unsigned NumA = 4096;
  localparam int unsigned NumB = 4096;
  localparam int unsigned DimW = $clog2(Dim);
  localparam int unsigned AddrW = 17;
  localparam int unsigned AccW = 56;

  localparam logic [1:0] MODE_LOAD_A = 2'd0;
  localparam logic [1:0] MODE_LOAD_B = 2'd1;
  localparam logic [1:0] MODE_FILTER = 2'd2;

  // Command from the front end to the back end
  typedef struct packed {
    logic [1:0]         mode;
    logic [11:0]        row;
    logic [11:0]        col;
    logic [DimW-1:0]    dim;
    logic signed [23:0] value;
    logic               zero_vec;
  } cmd_t;

endpackage

FILE: hw/rtl/dptm_front.sv
// ----------------------------------------------------------------------------
// dptm_front
// Accepts input transactions, drops ignored ones and queues commands.
// ----------------------------------------------------------------------------
module dptm_front
  import dptm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [11:0] in_row,
  input  logic [11:0] in_col,
  input  logic [4:0]  in_dim,
  input  logic signed [23:0] in_value,
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output cmd_t        cmd
);

  cmd_t       q_r [2];
  logic [1:0] cnt_r;
  logic       wp_r, rp_r;
  logic       keep, push, pop;
  cmd_t       c;

  // Classify the incoming item
  always_comb begin
    c.mode = in_mode;
    c.row = in_row;
    c.col = in_col;
    c.dim = in_dim[DimW-1:0];
    c.value = in_value;
    c.zero_vec = (32'(in_row) >= NumA) || (32'(in_col) >= NumB);
    case (in_mode)
      MODE_LOAD_A: keep = (32'(in_row) < NumA) && (32'(in_dim) < Dim);
      MODE_LOAD_B: keep = (32'(in_col) < NumB) && (32'(in_dim) < Dim);
      MODE_FILTER: keep = 1'b1;
      default:     keep = 1'b0;
    endcase
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push = in_valid && in_ready && keep;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop = cmd_valid && cmd_ready;
  assign cmd = q_r[rp_r];

  // Hold the two-entry queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) q_r[wp_r] <= c;
  end

endmodule

FILE: hw/rtl/dptm_back.sv
// ----------------------------------------------------------------------------
// dptm_back
// Writes the vector stores and runs the multiply-accumulate for filters.
// ----------------------------------------------------------------------------
module dptm_back
  import dptm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd,
  input  logic signed [AccW-1:0] threshold,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_row_out,
  output logic [11:0] out_col_out,
  output logic signed [23:0] out_value_out
);
  `include "dot_product_threshold_mask_unit_defines.svh"

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN, S_DONE} state_t;

  logic signed [23:0] a_mem [NumA*Dim];
  logic signed [23:0] b_mem [NumB*Dim];

  state_t state_r;
  cmd_t   cur_r;
  logic [DimW:0] k_r;
  logic [2:0]    pv_r;
  logic signed [23:0] ad_r, bd_r;
  logic signed [47:0] prod_r;
  logic signed [AccW-1:0] acc_r;
  logic out_valid_r;
  logic [11:0] orow_r, ocol_r;
  logic signed [23:0] oval_r;
  logic [AddrW-1:0] wa, ra, rb;
  logic take;

  assign cmd_ready = (state_r == S_IDLE) && !out_valid_r;
  assign take = cmd_valid && cmd_ready;
  assign wa = {(cmd.mode == MODE_LOAD_A) ? cmd.row : cmd.col, cmd.dim};
  assign ra = {cur_r.row, k_r[DimW-1:0]};
  assign rb = {cur_r.col, k_r[DimW-1:0]};

  // Write the stores on load commands
  always_ff @(posedge clk) begin
    if (take && cmd.mode == MODE_LOAD_A) a_mem[wa] <= cmd.value;
    if (take && cmd.mode == MODE_LOAD_B) b_mem[wa] <= cmd.value;
    ad_r <= a_mem[ra];
    bd_r <= b_mem[rb];
  end

  // Sequence the reads, multiply, accumulate and result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      pv_r <= '0;
      k_r <= '0;
    end else begin
      out_valid_r <= (state_r == S_DONE) || (out_valid_r && !out_ready);
      pv_r <= {pv_r[1:0], state_r == S_RUN};
      case (state_r)
        S_IDLE: begin
          if (take && cmd.mode == MODE_FILTER) begin
            cur_r <= cmd;
            k_r <= '0;
            acc_r <= '0;
            state_r <= cmd.zero_vec ? S_DONE : S_RUN;
          end
        end
        S_RUN: begin
          k_r <= k_r + 1'b1;
          if (k_r == (DimW+1)'(Dim - 1)) state_r <= S_DRAIN;
        end
        S_DRAIN: begin
          if (pv_r == '0) state_r <= S_DONE;
        end
        S_DONE: begin
          orow_r <= cur_r.row;
          ocol_r <= cur_r.col;
          oval_r <= (acc_r < threshold) ? '0 : cur_r.value;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
      // pv_r[0]: read data valid; pv_r[1]: product valid
      if (pv_r[0]) prod_r <= ad_r * bd_r;
      if (pv_r[1]) acc_r <= acc_r + AccW'(prod_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_row_out = orow_r;
  assign out_col_out = ocol_r;
  assign out_value_out = oval_r;

  `DPT_ASSERT_IMP(a_no_take_busy, state_r != S_IDLE, !cmd_ready, "command taken while busy")
  `DPT_ASSERT_NXT(a_done_out, state_r == S_DONE, out_valid, "result missing after filter")
  `DPT_ASSERT_IMP(a_out_idle, out_valid, state_r == S_IDLE, "result while filter runs")

endmodule

FILE: hw/rtl/dot_product_threshold_mask_unit.sv
// A filter transaction passes through the queue, then reads the stores for
// each of the Dim elements through one shared multiply-accumulate, drains
// the read, multiply and accumulate stages and registers the result; a
// filter whose row or column is out of range skips the reads. The back end
// takes its next command only once that result has been accepted. Load
// transactions write their store when the back end takes them. A two-entry
// queue decouples input acceptance from the execution engine. The stores
// are undefined until written; no clearing pass is run.
// ----------------------------------------------------------------------------
// dot_product_threshold_mask_unit
// Top level: threshold register, front end queue and execution back end.
// ----------------------------------------------------------------------------
module dot_product_threshold_mask_unit
  import dptm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic signed [55:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [11:0] in_row,
  input  logic [11:0] in_col,
  input  logic [4:0]  in_dim,
  input  logic signed [23:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_row_out,
  output logic [11:0] out_col_out,
  output logic signed [23:0] out_value_out
);

  logic signed [55:0] threshold_r;
  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  // Hold the threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) threshold_r <= '0;
    else if (cfg_we) threshold_r <= cfg_wdata;
  end

  dptm_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_mode, .in_row, .in_col, .in_dim,
    .in_value, .cmd_valid, .cmd_ready, .cmd
  );

  dptm_back u_back (
    .clk, .rst_n, .cmd_valid, .cmd_ready, .cmd, .threshold(threshold_r),
    .out_valid, .out_ready, .out_row_out, .out_col_out, .out_value_out
  );

endmodule
